// ===== sv/ohlc_pkg.sv =====
package ohlc_pkg;

    localparam int PERIOD_WIDTH = 17;
    localparam int COUNT_WIDTH  = 32;

    localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 17'd60;
    localparam logic [COUNT_WIDTH-1:0]  COUNT_MAX    = 32'hFFFF_FFFF;

    typedef enum logic [0:0] {
        CFG_PERIOD  = 1'b0,
        CFG_SESSION = 1'b1
    } cfg_idx_t;

    typedef enum logic [0:0] {
        KIND_BAR  = 1'b0,
        KIND_FILL = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV1,
        ST_CALC,
        ST_DIV2,
        ST_EMIT_BAR,
        ST_EMIT_FILL,
        ST_OPEN
    } state_t;

    typedef struct packed {
        logic accept;       // latch incoming tick
        logic update;       // fold tick into current bar
        logic div_start;
        logic div_sel;      // 0: time since session start, 1: gap to new period
        logic latch_new;    // new period start from remainder
        logic zero_count;
        logic latch_count;
        logic load_bar;
        logic load_fill;
        logic open;
    } cmd_t;

    typedef struct packed {
        logic early;
        logic no_bar;
        logic stale;
        logic in_period;
        logic div_done;
        logic need_fill;
        logic count_zero;
        logic out_free;
    } status_t;

endpackage

// ===== sv/ohlc_bar_aggregator_unit.sv =====
// OHLC bar aggregator.
// Input channel (s_valid/s_ready): one trade tick per transfer, time in whole
// seconds and price in units of 0.0001. Output channel (m_valid/m_ready): bar
// results; kind 0 is a finished bar, kind 1 a run of flat filler bars at the
// last close with its saturating repeat count. m_last marks the final result
// of a tick. Ticks that only update the bar, or are dropped, give no result.
// Config port (cfg_wr_en/cfg_index/cfg_wdata): index 0 period in seconds,
// index 1 session start; write only while the block is idle.
// Timing: a tick is held for one serial divide when it opens a bar, two
// divides when it crosses a period boundary with skipped periods. Dropped
// and in-period ticks need no divide; a boundary tick also waits out any
// output stall. The divider yields one quotient bit per cycle.
// Results go out through a single output register, so the next tick is taken
// while the last result waits for m_ready; a second result waits for the
// register to free up. Reset restores period 60, session start 0, and clears
// the open bar and the output register.
module ohlc_bar_aggregator_unit #(
    parameter int TIME_WIDTH  = 34,
    parameter int PRICE_WIDTH = 40
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [0:0]                          cfg_index,
    input  logic [TIME_WIDTH-1:0]               cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [TIME_WIDTH-1:0]               s_tick_time,
    input  logic [PRICE_WIDTH-1:0]              s_tick_price,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_kind,
    output logic [PRICE_WIDTH-1:0]              m_open_price,
    output logic [PRICE_WIDTH-1:0]              m_high_price,
    output logic [PRICE_WIDTH-1:0]              m_low_price,
    output logic [PRICE_WIDTH-1:0]              m_close_price,
    output logic [TIME_WIDTH-1:0]               m_bar_start_time,
    output logic [ohlc_pkg::COUNT_WIDTH-1:0]    m_repeat_count,
    output logic                                m_last
);
    import ohlc_pkg::*;

    cmd_t    cmd;
    status_t status;

    ohlc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ohlc_dp #(
        .TIME_WIDTH  (TIME_WIDTH),
        .PRICE_WIDTH (PRICE_WIDTH)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_idx_t'(cfg_index)),
        .cfg_wdata        (cfg_wdata),
        .s_tick_time      (s_tick_time),
        .s_tick_price     (s_tick_price),
        .cmd              (cmd),
        .status           (status),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_open_price     (m_open_price),
        .m_high_price     (m_high_price),
        .m_low_price      (m_low_price),
        .m_close_price    (m_close_price),
        .m_bar_start_time (m_bar_start_time),
        .m_repeat_count   (m_repeat_count),
        .m_last           (m_last)
    );

endmodule

// ===== sv/ohlc_div.sv =====
module ohlc_div #(
    parameter int TIME_WIDTH = 34
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [TIME_WIDTH-1:0]               dividend,
    input  logic [ohlc_pkg::PERIOD_WIDTH-1:0]   divisor,
    output logic                                done,
    output logic [TIME_WIDTH-1:0]               quotient,
    output logic [ohlc_pkg::PERIOD_WIDTH-1:0]   remainder
);
    import ohlc_pkg::*;

    localparam int CNT_W = $clog2(TIME_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_WIDTH - 1);

    logic                    busy_reg;
    logic                    done_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [TIME_WIDTH-1:0]   quo_reg;
    logic [PERIOD_WIDTH-1:0] rem_reg;
    logic [PERIOD_WIDTH-1:0] dvs_reg;

    logic [PERIOD_WIDTH:0]   trial;
    logic [PERIOD_WIDTH:0]   diff;
    logic                    fits;

    // restoring step: one quotient bit per cycle, MSB first
    assign trial = {rem_reg, quo_reg[TIME_WIDTH-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[TIME_WIDTH-2:0], fits};
            rem_reg <= fits ? diff[PERIOD_WIDTH-1:0] : trial[PERIOD_WIDTH-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== sv/ohlc_dp.sv =====
module ohlc_dp #(
    parameter int TIME_WIDTH  = 34,
    parameter int PRICE_WIDTH = 40
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  ohlc_pkg::cfg_idx_t                  cfg_index,
    input  logic [TIME_WIDTH-1:0]               cfg_wdata,
    input  logic [TIME_WIDTH-1:0]               s_tick_time,
    input  logic [PRICE_WIDTH-1:0]              s_tick_price,
    input  ohlc_pkg::cmd_t                      cmd,
    output ohlc_pkg::status_t                   status,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_kind,
    output logic [PRICE_WIDTH-1:0]              m_open_price,
    output logic [PRICE_WIDTH-1:0]              m_high_price,
    output logic [PRICE_WIDTH-1:0]              m_low_price,
    output logic [PRICE_WIDTH-1:0]              m_close_price,
    output logic [TIME_WIDTH-1:0]               m_bar_start_time,
    output logic [ohlc_pkg::COUNT_WIDTH-1:0]    m_repeat_count,
    output logic                                m_last
);
    import ohlc_pkg::*;

    logic [PERIOD_WIDTH-1:0] period_reg;
    logic [TIME_WIDTH-1:0]   session_reg;

    logic [TIME_WIDTH-1:0]   time_reg;
    logic [PRICE_WIDTH-1:0]  price_reg;

    logic [PRICE_WIDTH-1:0]  open_reg;
    logic [PRICE_WIDTH-1:0]  high_reg;
    logic [PRICE_WIDTH-1:0]  low_reg;
    logic [PRICE_WIDTH-1:0]  close_reg;
    logic [TIME_WIDTH-1:0]   cur_start_reg;
    logic                    bar_flag_reg;

    logic [TIME_WIDTH-1:0]   new_start_reg;
    logic [COUNT_WIDTH-1:0]  count_reg;

    logic                    out_valid_reg;
    kind_t                   out_kind_reg;
    logic [PRICE_WIDTH-1:0]  out_open_reg;
    logic [PRICE_WIDTH-1:0]  out_high_reg;
    logic [PRICE_WIDTH-1:0]  out_low_reg;
    logic [PRICE_WIDTH-1:0]  out_close_reg;
    logic [TIME_WIDTH-1:0]   out_start_reg;
    logic [COUNT_WIDTH-1:0]  out_count_reg;
    logic                    out_last_reg;

    logic [PERIOD_WIDTH-1:0] per_eff;
    logic [TIME_WIDTH-1:0]   per_t;
    logic [TIME_WIDTH-1:0]   fill_start;
    logic [TIME_WIDTH-1:0]   div_dividend;
    logic                    div_done;
    logic [TIME_WIDTH-1:0]   div_quo;
    logic [PERIOD_WIDTH-1:0] div_rem;
    logic [COUNT_WIDTH-1:0]  count_sat;

    // zero period acts as one second
    assign per_eff    = (period_reg == '0) ? PERIOD_WIDTH'(1) : period_reg;
    assign per_t      = TIME_WIDTH'(per_eff);
    assign fill_start = cur_start_reg + per_t;

    assign div_dividend = cmd.div_sel ? (new_start_reg - fill_start)
                                      : (time_reg - session_reg);

    assign count_sat = (div_quo > TIME_WIDTH'(COUNT_MAX)) ? COUNT_MAX
                                                          : div_quo[COUNT_WIDTH-1:0];

    ohlc_div #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (per_eff),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        status.early      = time_reg < session_reg;
        status.no_bar     = !bar_flag_reg;
        status.stale      = time_reg < cur_start_reg;
        status.in_period  = (time_reg - cur_start_reg) < per_t;
        status.div_done   = div_done;
        status.need_fill  = new_start_reg > fill_start;
        status.count_zero = count_reg == '0;
        status.out_free   = !out_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= PERIOD_RESET;
            session_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PERIOD:  period_reg  <= cfg_wdata[PERIOD_WIDTH-1:0];
                CFG_SESSION: session_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bar_flag_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.open) begin
                bar_flag_reg <= 1'b1;
            end
            if (cmd.load_bar || cmd.load_fill) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            time_reg  <= s_tick_time;
            price_reg <= s_tick_price;
        end
        if (cmd.update) begin
            if (price_reg > high_reg) begin
                high_reg <= price_reg;
            end
            if (price_reg < low_reg) begin
                low_reg <= price_reg;
            end
            close_reg <= price_reg;
        end
        if (cmd.open) begin
            open_reg      <= price_reg;
            high_reg      <= price_reg;
            low_reg       <= price_reg;
            close_reg     <= price_reg;
            cur_start_reg <= new_start_reg;
        end
        // aligned start is the tick time less its offset into the period
        if (cmd.latch_new) begin
            new_start_reg <= time_reg - TIME_WIDTH'(div_rem);
        end
        if (cmd.zero_count) begin
            count_reg <= '0;
        end else if (cmd.latch_count) begin
            count_reg <= count_sat;
        end
        if (cmd.load_bar) begin
            out_kind_reg  <= KIND_BAR;
            out_open_reg  <= open_reg;
            out_high_reg  <= high_reg;
            out_low_reg   <= low_reg;
            out_close_reg <= close_reg;
            out_start_reg <= cur_start_reg;
            out_count_reg <= COUNT_WIDTH'(1);
            out_last_reg  <= count_reg == '0;
        end else if (cmd.load_fill) begin
            out_kind_reg  <= KIND_FILL;
            out_open_reg  <= close_reg;
            out_high_reg  <= close_reg;
            out_low_reg   <= close_reg;
            out_close_reg <= close_reg;
            out_start_reg <= fill_start;
            out_count_reg <= count_reg;
            out_last_reg  <= 1'b1;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_kind           = out_kind_reg;
    assign m_open_price     = out_open_reg;
    assign m_high_price     = out_high_reg;
    assign m_low_price      = out_low_reg;
    assign m_close_price    = out_close_reg;
    assign m_bar_start_time = out_start_reg;
    assign m_repeat_count   = out_count_reg;
    assign m_last           = out_last_reg;

endmodule

// ===== sv/ohlc_ctrl.sv =====
module ohlc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ohlc_pkg::status_t    status,
    output ohlc_pkg::cmd_t       cmd
);
    import ohlc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.early) begin
                    state_next = ST_IDLE;
                end else if (status.no_bar) begin
                    state_next = ST_DIV1;
                end else if (status.stale || status.in_period) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1: begin
                if (status.div_done) begin
                    state_next = status.no_bar ? ST_OPEN : ST_CALC;
                end
            end
            ST_CALC: begin
                state_next = status.need_fill ? ST_DIV2 : ST_EMIT_BAR;
            end
            ST_DIV2: begin
                if (status.div_done) begin
                    state_next = ST_EMIT_BAR;
                end
            end
            ST_EMIT_BAR: begin
                if (status.out_free) begin
                    state_next = status.count_zero ? ST_OPEN : ST_EMIT_FILL;
                end
            end
            ST_EMIT_FILL: begin
                if (status.out_free) begin
                    state_next = ST_OPEN;
                end
            end
            ST_OPEN: begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_CHECK: begin
                if (!status.early) begin
                    if (status.no_bar) begin
                        cmd.div_start = 1'b1;
                    end else if (!status.stale) begin
                        cmd.update    = status.in_period;
                        cmd.div_start = !status.in_period;
                    end
                end
            end
            ST_DIV1: begin
                cmd.latch_new = status.div_done;
            end
            ST_CALC: begin
                cmd.div_sel    = 1'b1;
                cmd.div_start  = status.need_fill;
                cmd.zero_count = !status.need_fill;
            end
            ST_DIV2: begin
                cmd.latch_count = status.div_done;
            end
            ST_EMIT_BAR: begin
                cmd.load_bar = status.out_free;
            end
            ST_EMIT_FILL: begin
                cmd.load_fill = status.out_free;
            end
            ST_OPEN: begin
                cmd.open = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ===== bench/ohlc_bar_aggregator_unit_test.sv =====
module ohlc_bar_aggregator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ohlc_pkg::*;

    localparam int TW = 34;
    localparam int PW = 40;
    localparam logic [63:0] TIME_MAX  = (64'd1 << TW) - 1;
    localparam logic [63:0] PRICE_MAX = (64'd1 << PW) - 1;
    // two serial divides plus a few control states, with margin
    localparam int SETTLE_CYCLES = 2 * TW + 30;
    localparam int CYCLE_LIMIT   = 1_000_000;

    typedef struct {
        kind_t                  kind;
        logic [PW-1:0]          open_px;
        logic [PW-1:0]          high_px;
        logic [PW-1:0]          low_px;
        logic [PW-1:0]          close_px;
        logic [TW-1:0]          start_time;
        logic [COUNT_WIDTH-1:0] repeats;
        logic                   last;
    } bar_result_t;

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   cfg_wr_en    = 1'b0;
    cfg_idx_t               cfg_index    = CFG_PERIOD;
    logic [TW-1:0]          cfg_wdata    = '0;
    logic                   s_valid      = 1'b0;
    logic                   s_ready;
    logic [TW-1:0]          s_tick_time  = '0;
    logic [PW-1:0]          s_tick_price = '0;
    logic                   m_valid;
    logic                   m_ready      = 1'b0;
    logic                   m_kind;
    logic [PW-1:0]          m_open_price;
    logic [PW-1:0]          m_high_price;
    logic [PW-1:0]          m_low_price;
    logic [PW-1:0]          m_close_price;
    logic [TW-1:0]          m_bar_start_time;
    logic [COUNT_WIDTH-1:0] m_repeat_count;
    logic                   m_last;

    // mirror of the block's registers and open bar
    logic [PERIOD_WIDTH-1:0] period_reg   = PERIOD_RESET;
    logic [TW-1:0]           session_reg  = '0;
    logic [PW-1:0]           bar_open_px  = '0;
    logic [PW-1:0]           bar_high_px  = '0;
    logic [PW-1:0]           bar_low_px   = '0;
    logic [PW-1:0]           bar_close_px = '0;
    logic [TW-1:0]           bar_start    = '0;
    bit                      bar_live     = 1'b0;

    bar_result_t bars_due[$];
    int          mismatches     = 0;
    int          cycle_count    = 0;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          hold_off       = 0;
    logic [63:0] market_clock   = '0;
    logic [63:0] price_walk     = 64'd1_000_000;

    ohlc_bar_aggregator_unit #(
        .TIME_WIDTH (TW),
        .PRICE_WIDTH(PW)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_tick_time     (s_tick_time),
        .s_tick_price    (s_tick_price),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_open_price    (m_open_price),
        .m_high_price    (m_high_price),
        .m_low_price     (m_low_price),
        .m_close_price   (m_close_price),
        .m_bar_start_time(m_bar_start_time),
        .m_repeat_count  (m_repeat_count),
        .m_last          (m_last)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL ohlc_bar_aggregator_unit");
            $finish;
        end
    end

    function automatic logic [63:0] period_len();
        return (period_reg == '0) ? 64'd1 : 64'(period_reg);
    endfunction

    function automatic logic [63:0] align_start(logic [63:0] t, logic [63:0] per);
        return session_reg + ((t - session_reg) / per) * per;
    endfunction

    function automatic void start_bar(logic [63:0] t, logic [63:0] px, logic [63:0] per);
        logic [63:0] aligned;
        aligned      = align_start(t, per);
        bar_start    = aligned[TW-1:0];
        bar_open_px  = px[PW-1:0];
        bar_high_px  = px[PW-1:0];
        bar_low_px   = px[PW-1:0];
        bar_close_px = px[PW-1:0];
        bar_live     = 1'b1;
    endfunction

    function automatic void expect_bar(bar_result_t r);
        bars_due.insert(bars_due.size(), r);
    endfunction

    // advance the bar state by one tick, queue the bars it completes
    function automatic void fold_tick(logic [63:0] t, logic [63:0] px);
        logic [63:0] per;
        logic [63:0] fill_start;
        logic [63:0] fresh_start;
        logic [63:0] count;
        bar_result_t r;
        per = period_len();
        if (t < session_reg)
            return;
        if (!bar_live) begin
            start_bar(t, px, per);
            return;
        end
        if (t < bar_start)
            return;
        if (t - bar_start < per) begin
            if (px > bar_high_px)
                bar_high_px = px[PW-1:0];
            if (px < bar_low_px)
                bar_low_px = px[PW-1:0];
            bar_close_px = px[PW-1:0];
            return;
        end
        fill_start  = bar_start + per;
        fresh_start = align_start(t, per);
        count = (fresh_start > fill_start) ? (fresh_start - fill_start) / per : 64'd0;
        if (count > COUNT_MAX)
            count = COUNT_MAX;
        r.kind       = KIND_BAR;
        r.open_px    = bar_open_px;
        r.high_px    = bar_high_px;
        r.low_px     = bar_low_px;
        r.close_px   = bar_close_px;
        r.start_time = bar_start;
        r.repeats    = COUNT_WIDTH'(1);
        r.last       = (count == 0);
        expect_bar(r);
        if (count != 0) begin
            r.kind       = KIND_FILL;
            r.open_px    = bar_close_px;
            r.high_px    = bar_close_px;
            r.low_px     = bar_close_px;
            r.start_time = fill_start[TW-1:0];
            r.repeats    = count[COUNT_WIDTH-1:0];
            r.last       = 1'b1;
            expect_bar(r);
        end
        start_bar(t, px, per);
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        bar_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (bars_due.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual kind %0d start %0d",
                         $time, m_kind, m_bar_start_time);
                mismatches++;
            end else begin
                want = bars_due.pop_front();
                check_field("kind", want.kind, m_kind);
                check_field("open_price", want.open_px, m_open_price);
                check_field("high_price", want.high_px, m_high_price);
                check_field("low_price", want.low_px, m_low_price);
                check_field("close_price", want.close_px, m_close_price);
                check_field("bar_start_time", want.start_time, m_bar_start_time);
                check_field("repeat_count", want.repeats, m_repeat_count);
                check_field("last", want.last, m_last);
            end
        end
    end

    // result side: long hold-off when requested, else random stalls
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // valid stays high on return so back-to-back calls stream without a bubble
    task automatic send_tick(logic [63:0] t, logic [63:0] px);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_tick_time  <= t[TW-1:0];
        s_tick_price <= px[PW-1:0];
        do @(posedge aclk); while (!s_ready);
        fold_tick(t & TIME_MAX, px & PRICE_MAX);
    endtask

    task automatic drain_and_settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (bars_due.size() != 0)
            @(posedge aclk);
        // dropped or in-period ticks may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[TW-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_PERIOD)
            period_reg = value[PERIOD_WIDTH-1:0];
        else
            session_reg = value[TW-1:0];
        @(posedge aclk);
    endtask

    function automatic logic [63:0] pick_tick_time();
        logic [63:0] per;
        logic [63:0] t;
        int unsigned roll;
        per  = period_len();
        roll = $urandom_range(99);
        if (roll < 7 && bar_start > 0)
            return bar_start - 1 - ($urandom_range(999) % bar_start);
        if (roll < 13 && session_reg > 0)
            return {$urandom, $urandom} % session_reg;
        if (roll < 64)
            t = market_clock + $urandom_range(per / 3);
        else if (roll < 90)
            t = market_clock + per * $urandom_range(2, 1);
        else
            t = market_clock + per * $urandom_range(1000, 3) + $urandom_range(per - 1);
        if (t > TIME_MAX)
            t = TIME_MAX;
        market_clock = t;
        return t;
    endfunction

    function automatic logic [63:0] pick_price();
        logic [63:0] step;
        if ($urandom_range(3) == 0) begin
            price_walk = {$urandom, $urandom} & PRICE_MAX;
        end else begin
            step = $urandom_range(2000);
            if ($urandom_range(1))
                price_walk = (price_walk > PRICE_MAX - step) ? PRICE_MAX : price_walk + step;
            else
                price_walk = (price_walk < step) ? 64'd0 : price_walk - step;
        end
        return price_walk;
    endfunction

    function automatic void catch_up_clock();
        if (market_clock < session_reg)
            market_clock = session_reg;
        if (market_clock < bar_start)
            market_clock = bar_start;
    endfunction

    task automatic test_basic_bars();
        send_tick(100, 5000);           // first tick opens the bar at 60
        send_tick(110, PRICE_MAX);
        send_tick(115, 0);
        send_tick(119, 7000);
        send_tick(50, 123);             // older than the bar, dropped
        send_tick(120, 8000);           // next period, no gap
        send_tick(179, 8100);
        send_tick(420, 9000);           // four skipped periods
        send_tick(479, 9100);
        send_tick(600, 9200);
    endtask

    task automatic test_config_extremes();
        logic [63:0] t;
        drain_and_settle();
        write_reg(CFG_PERIOD, 0);       // zero period acts as one second
        write_reg(CFG_SESSION, 1000);
        send_tick(999, 1);              // before session start
        send_tick(1000, 2);
        send_tick(1000, 3);
        t = 1000 + (64'd1 << 32) + 5;   // gap wide enough to saturate the count
        send_tick(t, 4);
        send_tick(t + 1, PRICE_MAX);
        drain_and_settle();
        write_reg(CFG_PERIOD, 86400);
        write_reg(CFG_SESSION, 7);      // boundaries move while a bar is open
        t = bar_start + 86400 * 3 + 11;
        send_tick(t, 42);
        send_tick(t + 1, 43);
    endtask

    task automatic test_random_phase(int n, int src_pct, int sink_pct);
        logic [63:0] per;
        logic [63:0] sess;
        drain_and_settle();
        case ($urandom_range(6))
            0: per = 64'd0;
            1: per = 64'd1;
            2: per = 64'd60;
            3: per = 64'd3600;
            4: per = 64'd86400;
            5: per = 64'd131071;
            default: per = $urandom_range(131071, 1);
        endcase
        case ($urandom_range(2))
            0: sess = session_reg;
            1: sess = bar_start + $urandom_range(100000);
            default: sess = bar_start - ($urandom_range(100000) % (bar_start + 1));
        endcase
        if (sess > TIME_MAX)
            sess = TIME_MAX;
        write_reg(CFG_PERIOD, per);
        write_reg(CFG_SESSION, sess);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        catch_up_clock();
        repeat (n) send_tick(pick_tick_time(), pick_price());
    endtask

    task automatic test_backpressure();
        drain_and_settle();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        catch_up_clock();
        hold_off = 500;
        // every tick closes a bar, so the output register backs up
        repeat (24) begin
            market_clock = market_clock + period_len() * $urandom_range(2, 1);
            send_tick(market_clock, pick_price());
        end
    endtask

    task automatic test_time_limits();
        drain_and_settle();
        write_reg(CFG_PERIOD, 3);
        write_reg(CFG_SESSION, TIME_MAX - 10);
        send_tick(TIME_MAX - 11, 1);
        send_tick(TIME_MAX, PRICE_MAX); // new bar at the top of the time range
        send_tick(TIME_MAX, 0);
        drain_and_settle();
        write_reg(CFG_PERIOD, 131071);
        write_reg(CFG_SESSION, TIME_MAX);
        send_tick(TIME_MAX - 1, 5);
        send_tick(TIME_MAX, 6);
    endtask

    initial begin
        int src_modes[4]  = '{0, 71, 0, 7};
        int sink_modes[4] = '{0, 0, 71, 7};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_basic_bars();
        test_config_extremes();
        for (int k = 0; k < 8; k++)
            test_random_phase(135, src_modes[k % 4], sink_modes[k % 4]);
        test_backpressure();
        test_time_limits();
        drain_and_settle();
        if (mismatches == 0)
            $display("PASS ohlc_bar_aggregator_unit");
        else
            $display("FAIL ohlc_bar_aggregator_unit");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ohlc_pkg.sv
sv/ohlc_div.sv
sv/ohlc_dp.sv
sv/ohlc_ctrl.sv
sv/ohlc_bar_aggregator_unit.sv
bench/ohlc_bar_aggregator_unit_test.sv
